FILE: rtl/rrts_pkg.sv
// Shared types and codes for the round-robin tick scheduler.
package rrts_pkg;

    typedef enum logic [0:0] {
        OP_ARRIVE = 1'b0,
        OP_TICK   = 1'b1
    } op_code_t;

    typedef enum logic [1:0] {
        EV_RUNNING  = 2'd0,
        EV_FINISHED = 2'd1,
        EV_IDLE     = 2'd2,
        EV_REJECT   = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_EXEC
    } bk_state_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic        is_tick;
        logic [7:0]  job_id;
        logic [15:0] burst;
    } cmd_t;

    // One ready-queue entry.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rem;
    } entry_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  job;
        logic [31:0] stamp;
        logic        last;
    } result_t;

    // Results written together into the output buffer in the same cycle.
    typedef struct packed {
        logic    push;
        logic    two;
        result_t first;
        result_t second;
    } res_push_t;

    localparam logic [15:0] MIN_BURST   = 16'd1;
    localparam logic [7:0]  MIN_QUANTUM = 8'd1;
    localparam logic [7:0]  SLICE_MAX   = 8'd255;

endpackage

FILE: rtl/rrts_front.sv
// Front end: accepts input items, classifies them and queues commands.
module rrts_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [23:0]    s_tdata,   // [7:0] job_id, [23:8] burst_length
    input  logic [0:0]     s_tuser,   // [0] opcode
    output logic           cmd_valid,
    output rrts_pkg::cmd_t cmd,
    input  logic           cmd_pop
);
    import rrts_pkg::*;

    cmd_t        ent_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    cmd_t        in_cmd;

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = ent_reg[rd_ptr_reg];

    // A zero burst is treated as one unit of work.
    always_comb begin
        in_cmd.is_tick = (s_tuser == OP_TICK);
        in_cmd.job_id  = s_tdata[7:0];
        in_cmd.burst   = (s_tdata[23:8] == 16'd0) ? MIN_BURST : s_tdata[23:8];
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/rrts_core.sv
// Back end: ready queue, running job, slice accounting and event generation.
module rrts_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                cmd_valid,
    input  rrts_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic                out_empty,
    output rrts_pkg::res_push_t res
);
    import rrts_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;

    entry_t      queue_mem [QUEUE_DEPTH];
    entry_t      rd_data_reg;
    logic        mem_we;
    entry_t      mem_wdata;

    bk_state_t   state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [15:0] cur_rem_reg, cur_rem_next;
    logic [7:0]  slice_reg, slice_next;
    logic        cur_valid_reg, cur_valid_next;
    logic        requeue_reg, requeue_next;
    logic [31:0] sys_time_reg, sys_time_next;
    logic [7:0]  quantum_reg, quantum_next;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic [AW-1:0] head_inc;
    logic        q_full, q_nonempty;
    logic        take_item;
    logic        pop_rq, pop_new, do_pop;
    logic [7:0]  eff_id;
    logic [15:0] eff_rem;
    logic [7:0]  eff_slice;
    logic        eff_valid;
    logic [15:0] rem_dec;
    logic [7:0]  slice_inc;
    logic [7:0]  quantum_eff;

    assign cfg_ready = 1'b1;

    assign tail_sum   = SW'(head_reg) + SW'(count_reg);
    assign tail       = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                        AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign head_inc   = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign q_full     = (count_reg == CW'(QUEUE_DEPTH));
    assign q_nonempty = (count_reg != '0);
    assign take_item  = cmd_valid && out_empty;

    // A job whose slice ran out is swapped with the queue head; with an
    // empty queue it keeps running on a fresh slice.
    assign pop_rq    = requeue_reg && q_nonempty;
    assign pop_new   = !cur_valid_reg && q_nonempty;
    assign do_pop    = pop_rq || pop_new;
    assign eff_id    = do_pop ? rd_data_reg.id : cur_id_reg;
    assign eff_rem   = do_pop ? rd_data_reg.rem : cur_rem_reg;
    assign eff_slice = (do_pop || requeue_reg) ? 8'd0 : slice_reg;
    assign eff_valid = cur_valid_reg || do_pop;
    assign rem_dec   = (eff_rem != 16'd0) ? eff_rem - 16'd1 : 16'd0;
    assign slice_inc = (eff_slice < SLICE_MAX) ? eff_slice + 8'd1 : eff_slice;
    assign quantum_eff = (quantum_reg == 8'd0) ? MIN_QUANTUM : quantum_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (take_item && cmd.is_tick) begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH: state_next = BK_EXEC;
            BK_EXEC:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        cur_id_next    = cur_id_reg;
        cur_rem_next   = cur_rem_reg;
        slice_next     = slice_reg;
        cur_valid_next = cur_valid_reg;
        requeue_next   = requeue_reg;
        sys_time_next  = sys_time_reg;
        quantum_next   = cfg_valid ? cfg_data : quantum_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = '{id: cmd.job_id, rem: cmd.burst};
        res            = '0;
        unique case (state_reg)
            BK_IDLE: begin
                if (take_item && !cmd.is_tick) begin
                    cmd_pop = 1'b1;
                    if (q_full) begin
                        res.push  = 1'b1;
                        res.first = '{kind: EV_REJECT, job: cmd.job_id,
                                      stamp: sys_time_reg, last: 1'b1};
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            BK_FETCH: begin
            end
            BK_EXEC: begin
                cmd_pop       = 1'b1;
                sys_time_next = sys_time_reg + 32'd1;
                requeue_next  = 1'b0;
                if (do_pop) begin
                    head_next = head_inc;
                end
                if (pop_new) begin
                    count_next = count_reg - CW'(1);
                end
                // The preempted job goes behind every job queued meanwhile;
                // the head was already read, so a full queue cannot overflow.
                if (pop_rq) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{id: cur_id_reg, rem: cur_rem_reg};
                end
                res.push = 1'b1;
                if (eff_valid) begin
                    cur_id_next = eff_id;
                    res.first   = '{kind: EV_RUNNING, job: eff_id,
                                    stamp: sys_time_reg, last: 1'b1};
                    if (rem_dec == 16'd0) begin
                        res.two         = 1'b1;
                        res.first.last  = 1'b0;
                        res.second      = '{kind: EV_FINISHED, job: eff_id,
                                            stamp: sys_time_reg + 32'd1, last: 1'b1};
                        cur_valid_next  = 1'b0;
                        cur_rem_next    = 16'd0;
                        slice_next      = 8'd0;
                    end else begin
                        cur_valid_next = 1'b1;
                        cur_rem_next   = rem_dec;
                        slice_next     = slice_inc;
                        requeue_next   = (slice_inc >= quantum_eff);
                    end
                end else begin
                    res.first = '{kind: EV_IDLE, job: 8'd0,
                                  stamp: sys_time_reg, last: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cur_id_reg    <= 8'd0;
            cur_rem_reg   <= 16'd0;
            slice_reg     <= 8'd0;
            cur_valid_reg <= 1'b0;
            requeue_reg   <= 1'b0;
            sys_time_reg  <= 32'd0;
            quantum_reg   <= MIN_QUANTUM;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cur_id_reg    <= cur_id_next;
            cur_rem_reg   <= cur_rem_next;
            slice_reg     <= slice_next;
            cur_valid_reg <= cur_valid_next;
            requeue_reg   <= requeue_next;
            sys_time_reg  <= sys_time_next;
            quantum_reg   <= quantum_next;
        end
    end

    // Ready queue storage: one write port at the tail, registered head read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            queue_mem[tail] <= mem_wdata;
        end
        rd_data_reg <= queue_mem[head_reg];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("ready queue count exceeds depth");

    a_requeue_running: assert property (@(posedge aclk) disable iff (!aresetn)
        requeue_reg |-> cur_valid_reg)
        else $error("requeue pending without a running job");

    a_exec_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EXEC) |-> (cmd_valid && cmd.is_tick && out_empty))
        else $error("tick execution without its command");

    a_push_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res.push |-> out_empty)
        else $error("results written into a busy output buffer");

endmodule

FILE: rtl/rrts_outbuf.sv
// Output buffer: holds up to two results of one item for the result channel.
module rrts_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrts_pkg::res_push_t res,
    output logic                out_empty,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [7:0] event_job, [39:8] event_time
    output logic [1:0]          m_tuser,   // [1:0] event_kind
    output logic                m_tlast    // last_event
);
    import rrts_pkg::*;

    result_t    ent0_reg, ent0_next;
    result_t    ent1_reg, ent1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_empty = (cnt_reg == 2'd0);
    assign m_tvalid  = !out_empty;
    assign pop       = m_tvalid && m_tready;
    assign m_tdata   = {ent0_reg.stamp, ent0_reg.job};
    assign m_tuser   = ent0_reg.kind;
    assign m_tlast   = ent0_reg.last;

    // Writes only land in an empty buffer, so they never meet a pop.
    always_comb begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        if (res.push) begin
            ent0_next = res.first;
            ent1_next = res.second;
            cnt_next  = res.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            ent0_next = ent1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

FILE: rtl/round_robin_tick_scheduler.sv
// Top level of the round-robin time-slice scheduler.
//
// Input items arrive on the s_ channel. An arrive item (opcode 0) places a
// job with its burst length at the tail of the ready queue, or, when the
// queue is full, yields one rejection event. A tick item (opcode 1) covers
// one time unit and yields a running event, a running and a finished event,
// or an idle event. Events leave on the m_ channel; m_tlast marks the final
// event of an item.
//
// The front end takes an item into a two-entry command queue. The back end
// handles an arrival at issue and takes a tick through issue, a registered
// ready-queue memory read and execute, and starts an item only once the
// output buffer is empty. Every event is registered in the output buffer
// before it reaches m_tvalid. The user must write the quantum on the cfg_
// channel only while idle; the block itself does not enforce this.
//
// Reset empties all queues, stops any running job, clears the time to zero
// and sets the quantum to one. When the receiver stalls, the output buffer
// holds its events and the command queue fills, after which s_tready drops.
module round_robin_tick_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] job_id, [23:8] burst_length
    input  logic [0:0]  s_tuser,    // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] event_job, [39:8] event_time
    output logic [1:0]  m_tuser,    // [1:0] event_kind
    output logic        m_tlast,    // last_event
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data    // quantum
);
    import rrts_pkg::*;

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      out_empty;
    res_push_t res;

    // Classification and buffering of incoming items.
    rrts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Scheduling state and the ready-queue memory.
    rrts_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_empty (out_empty),
        .res       (res)
    );

    // Events wait here until the receiver takes them.
    rrts_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .out_empty (out_empty),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
